[src/rsks_pkg.sv]
// shared types, constants and helpers for the record sort and key search unit
// depends on nothing; every other file of the block but rsks_ram imports it
package rsks_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int KEY_CHARS   = 9;
    localparam int TAG_BITS    = 16;

    // field widths fixed by the channel payload
    localparam int CMD_W       = 2;
    localparam int HEAD_W      = 64;
    localparam int TAIL_W      = 8;
    localparam int TAG_FIELD_W = 16;
    localparam int KEY_SLOTS   = 9;
    localparam int KEY_W       = HEAD_W + TAIL_W;

    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        key_t                key;
        logic [TAG_BITS-1:0] tag;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SORT   = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_RDATA,
        PUSH_PEND,
        PUSH_MARK
    } push_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MARK,
        ST_LDI,
        ST_LDW,
        ST_SRD,
        ST_SCMP,
        ST_SWI,
        ST_LRD,
        ST_LOUT,
        ST_QRD,
        ST_QCMP,
        ST_QEND
    } state_t;

    typedef struct packed {
        logic      store_item;
        logic      clear_count;
        logic      take_query;
        logic      rd_i;
        logic      rd_j;
        logic      load_cur;
        logic      init_j;
        logic      inc_j;
        logic      clr_j;
        logic      inc_i;
        logic      clr_i;
        logic      cmp_step;
        logic      wr_cur_i;
        logic      take_pend;
        logic      clr_pend;
        push_sel_t push_sel;
        logic      push_last;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic count_one;
        logic last_i;
        logic last_j;
        logic key_ge;
        logic key_match;
        logic out_free;
        logic pend_valid;
    } dp_stat_t;

    // zero every character after the first nul or beyond the key length
    function automatic key_t norm_key(logic [HEAD_W-1:0] head, logic [TAIL_W-1:0] tail);
        key_t k;
        logic ended;
        k     = {head, tail};
        ended = 1'b0;
        for (int p = 0; p < KEY_SLOTS; p++)
        begin
            if (k[KEY_W-1-8*p -: 8] == 8'd0 || p >= KEY_CHARS)
            begin
                ended = 1'b1;
            end
            if (ended)
            begin
                k[KEY_W-1-8*p -: 8] = 8'd0;
            end
        end
        return k;
    endfunction

endpackage

[src/rsks_if.sv]
// valid/ready channel interfaces for the command and result streams
// depends on rsks_pkg for the payload widths
interface rsks_in_if import rsks_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       cmd;
    logic [HEAD_W-1:0]      key_head;
    logic [TAIL_W-1:0]      key_tail;
    logic [TAG_FIELD_W-1:0] record_tag;

    modport source (output valid, cmd, key_head, key_tail, record_tag, input ready);
    modport sink   (input valid, cmd, key_head, key_tail, record_tag, output ready);
endinterface

interface rsks_out_if import rsks_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [HEAD_W-1:0]      out_key_head;
    logic [TAIL_W-1:0]      out_key_tail;
    logic [TAG_FIELD_W-1:0] out_tag;
    logic                   out_valid;
    logic                   out_last;

    modport source (output valid, out_key_head, out_key_tail, out_tag, out_valid, out_last,
                    input ready);
    modport sink   (input valid, out_key_head, out_key_tail, out_tag, out_valid, out_last,
                    output ready);
endinterface

[src/rsks_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module rsks_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/rsks_dp.sv]
// datapath: record store, sort and search indices, carried record and result register
// depends on rsks_pkg and rsks_ram
module rsks_dp import rsks_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [HEAD_W-1:0]      key_head,
    input  logic [TAIL_W-1:0]      key_tail,
    input  logic [TAG_FIELD_W-1:0] record_tag,
    input  logic                   result_ready,
    output logic                   result_valid,
    output logic [HEAD_W-1:0]      out_key_head,
    output logic [TAIL_W-1:0]      out_key_tail,
    output logic [TAG_FIELD_W-1:0] out_tag,
    output logic                   out_valid,
    output logic                   out_last,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat
);

    cnt_t count_reg, count_next;
    idx_t i_reg, i_next;
    idx_t j_reg, j_next;
    rec_t cur_reg, cur_next;
    rec_t pend_reg, pend_next;
    logic pend_valid_reg, pend_valid_next;
    key_t query_reg, query_next;
    rec_t obuf_reg, obuf_next;
    logic olast_reg, olast_next;
    logic orec_reg, orec_next;
    logic ovalid_reg, ovalid_next;

    logic we;
    idx_t waddr;
    rec_t wdata;
    logic re;
    idx_t raddr;
    rec_t rdata;
    logic [REC_W-1:0] rdata_raw;
    rec_t item_rec;

    rsks_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata = rec_t'(rdata_raw);

    always_comb
    begin
        item_rec.key = norm_key(key_head, key_tail);
        item_rec.tag = record_tag[TAG_BITS-1:0];
    end

    // status towards the controller
    always_comb
    begin
        stat.full       = (count_reg == CNT_W'(MAX_RECORDS));
        stat.count_zero = (count_reg == '0);
        stat.count_one  = (count_reg == CNT_W'(1));
        stat.last_i     = (CNT_W'(i_reg) + CNT_W'(2) == count_reg);
        stat.last_j     = (CNT_W'(j_reg) + CNT_W'(1) == count_reg);
        stat.key_ge     = (cur_reg.key >= rdata.key);
        stat.key_match  = (rdata.key == query_reg);
        stat.out_free   = !ovalid_reg || result_ready;
        stat.pend_valid = pend_valid_reg;
    end

    // store port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = j_reg;
        wdata = cur_reg;
        priority if (cmd.store_item)
        begin
            we    = 1'b1;
            waddr = count_reg[IDX_W-1:0];
            wdata = item_rec;
        end
        else if (cmd.cmp_step && stat.key_ge)
        begin
            we    = 1'b1;
            waddr = j_reg;
            wdata = cur_reg;
        end
        else if (cmd.wr_cur_i)
        begin
            we    = 1'b1;
            waddr = i_reg;
            wdata = cur_reg;
        end
        re    = cmd.rd_i || cmd.rd_j;
        raddr = cmd.rd_i ? i_reg : j_reg;
    end

    always_comb
    begin
        count_next      = count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        query_next      = query_reg;
        obuf_next       = obuf_reg;
        olast_next      = olast_reg;
        orec_next       = orec_reg;
        ovalid_next     = ovalid_reg && !result_ready;

        if (cmd.store_item)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        if (cmd.take_query)
        begin
            query_next = item_rec.key;
        end
        if (cmd.clr_i)
        begin
            i_next = '0;
        end
        if (cmd.inc_i)
        begin
            i_next = i_reg + IDX_W'(1);
        end
        if (cmd.clr_j)
        begin
            j_next = '0;
        end
        if (cmd.init_j)
        begin
            j_next = i_reg + IDX_W'(1);
        end
        if (cmd.inc_j)
        begin
            j_next = j_reg + IDX_W'(1);
        end
        if (cmd.load_cur)
        begin
            cur_next = rdata;
        end
        // exchange: the smaller key stays in the carried slot
        if (cmd.cmp_step && stat.key_ge)
        begin
            cur_next = rdata;
        end
        if (cmd.clr_pend)
        begin
            pend_valid_next = 1'b0;
        end
        if (cmd.take_pend)
        begin
            pend_next       = rdata;
            pend_valid_next = 1'b1;
        end

        unique case (cmd.push_sel)
            PUSH_RDATA:
            begin
                obuf_next   = rdata;
                orec_next   = 1'b1;
                olast_next  = cmd.push_last;
                ovalid_next = 1'b1;
            end
            PUSH_PEND:
            begin
                obuf_next   = pend_reg;
                orec_next   = 1'b1;
                olast_next  = cmd.push_last;
                ovalid_next = 1'b1;
            end
            PUSH_MARK:
            begin
                obuf_next   = '0;
                orec_next   = 1'b0;
                olast_next  = 1'b1;
                ovalid_next = 1'b1;
            end
            PUSH_NONE:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            pend_valid_reg <= pend_valid_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        pend_reg  <= pend_next;
        query_reg <= query_next;
        obuf_reg  <= obuf_next;
        olast_reg <= olast_next;
        orec_reg  <= orec_next;
    end

    assign result_valid = ovalid_reg;
    assign out_key_head = obuf_reg.key[KEY_W-1 -: HEAD_W];
    assign out_key_tail = obuf_reg.key[TAIL_W-1:0];
    assign out_tag      = TAG_FIELD_W'(obuf_reg.tag);
    assign out_valid    = orec_reg;
    assign out_last     = olast_reg;

endmodule

[src/rsks_ctrl.sv]
// controller: sequences loads, the exchange sort, listing and key search
// depends on rsks_pkg
module rsks_ctrl import rsks_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [CMD_W-1:0] item_cmd,
    output logic             item_ready,
    output dp_cmd_t          cmd,
    input  dp_stat_t         stat
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        cmd.push_sel = PUSH_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    unique case (cmd_t'(item_cmd))
                        CMD_LOAD:
                        begin
                            cmd.store_item = !stat.full;
                        end
                        CMD_CLEAR:
                        begin
                            cmd.clear_count = 1'b1;
                        end
                        CMD_SORT:
                        begin
                            priority if (stat.count_zero)
                            begin
                                state_next = ST_MARK;
                            end
                            else if (stat.count_one)
                            begin
                                cmd.clr_j  = 1'b1;
                                state_next = ST_LRD;
                            end
                            else
                            begin
                                cmd.clr_i  = 1'b1;
                                state_next = ST_LDI;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            cmd.take_query = 1'b1;
                            cmd.clr_j      = 1'b1;
                            cmd.clr_pend   = 1'b1;
                            state_next     = stat.count_zero ? ST_QEND : ST_QRD;
                        end
                    endcase
                end
            end

            ST_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.push_sel  = PUSH_MARK;
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            // one outer pass: fetch entry i into the carried slot
            ST_LDI:
            begin
                cmd.rd_i   = 1'b1;
                state_next = ST_LDW;
            end
            ST_LDW:
            begin
                cmd.load_cur = 1'b1;
                cmd.init_j   = 1'b1;
                state_next   = ST_SRD;
            end
            ST_SRD:
            begin
                cmd.rd_j   = 1'b1;
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                cmd.cmp_step = 1'b1;
                if (stat.last_j)
                begin
                    state_next = ST_SWI;
                end
                else
                begin
                    cmd.inc_j  = 1'b1;
                    state_next = ST_SRD;
                end
            end
            ST_SWI:
            begin
                cmd.wr_cur_i = 1'b1;
                if (stat.last_i)
                begin
                    cmd.clr_j  = 1'b1;
                    state_next = ST_LRD;
                end
                else
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = ST_LDI;
                end
            end

            ST_LRD:
            begin
                cmd.rd_j   = 1'b1;
                state_next = ST_LOUT;
            end
            ST_LOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.push_sel  = PUSH_RDATA;
                    cmd.push_last = stat.last_j;
                    if (stat.last_j)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.inc_j  = 1'b1;
                        state_next = ST_LRD;
                    end
                end
            end

            ST_QRD:
            begin
                cmd.rd_j   = 1'b1;
                state_next = ST_QCMP;
            end
            // a match is held in the pending slot until the next one, so the final one can carry last
            ST_QCMP:
            begin
                if (!(stat.key_match && stat.pend_valid && !stat.out_free))
                begin
                    if (stat.key_match)
                    begin
                        if (stat.pend_valid)
                        begin
                            cmd.push_sel = PUSH_PEND;
                        end
                        cmd.take_pend = 1'b1;
                    end
                    if (stat.last_j)
                    begin
                        state_next = ST_QEND;
                    end
                    else
                    begin
                        cmd.inc_j  = 1'b1;
                        state_next = ST_QRD;
                    end
                end
            end
            ST_QEND:
            begin
                if (stat.out_free)
                begin
                    cmd.push_sel  = stat.pend_valid ? PUSH_PEND : PUSH_MARK;
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/record_sort_and_key_search_unit.sv]
// Record store with exchange sort and key search; uses rsks_pkg, rsks_if, rsks_ctrl, rsks_dp.
// Loads and clears are accepted one per cycle while the unit is idle, and they give no result.
// A search reads and compares each record in turn, then gives the final result. Sort and list
// sorts the store with exchange passes and then lists every record; an empty store gives a
// single end mark. Input is held off until the command ends, and result stalls hold it up.
// Reset zeroes the count, indices, valid flags and state; the store is kept, with no clearing pass.
module record_sort_and_key_search_unit import rsks_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    rsks_in_if.sink     item,
    rsks_out_if.source  result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rsks_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_cmd   (item.cmd),
        .item_ready (item.ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    rsks_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_head     (item.key_head),
        .key_tail     (item.key_tail),
        .record_tag   (item.record_tag),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .out_key_head (result.out_key_head),
        .out_key_tail (result.out_key_tail),
        .out_tag      (result.out_tag),
        .out_valid    (result.out_valid),
        .out_last     (result.out_last),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
